### rtl/bta_pkg.sv
// Shared constants, status codes and sequencer states of the block table allocator.
package bta_pkg;

    localparam int NUM_BLOCKS_DEF  = 512;
    localparam int BLOCK_BYTES_DEF = 32;

    localparam int REQ_W   = 15;
    localparam int OFF_W   = 15;
    localparam int START_W = 14;
    localparam int FREE_W  = 15;
    localparam int DIV_W   = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_REQ,
        S_DIV_OFF,
        S_REL_LEN,
        S_REL,
        S_SCAN_GO,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

endpackage

### rtl/bta_div.sv
// Divider by a fixed divisor through reciprocal multiplication, quotient registered in the cycle after start.
module bta_div #(
    parameter int DIVISOR = bta_pkg::BLOCK_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [bta_pkg::DIV_W-1:0] i_dividend,
    output logic                     o_done,
    output logic [bta_pkg::DIV_W-1:0] o_quotient
);
    import bta_pkg::*;

    localparam int SH = DIV_W + $clog2(DIVISOR);
    localparam int MW = DIV_W + 1;
    localparam int PW = DIV_W + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

    logic             r_done;
    logic [DIV_W-1:0] r_quo;

    logic [PW-1:0] prod;
    logic [PW-1:0] prod_sh;

    assign prod    = PW'(i_dividend) * PW'(RECIP_V);
    assign prod_sh = prod >> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= prod_sh[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/block_table_allocator_core.sv
// Top level of the block table allocator: sequencer, divider, block table and result register.
// Fixed-block heap allocator. After reset the table is cleared one entry per cycle, so
// no beat is accepted until the whole table is cleared. One item is in work at a time.
// A free scales the offset to a block, reads the run length, visits each entry of the
// run and then leaves the loop, and hands off the result; an ignored free and a
// zero-size allocate go straight to the hand-off. An allocate scales the request size,
// scans table entries from the top downward (at most NUM_BLOCKS), marks each block of
// the run, and hands off; when it frees first, the free steps come after the scaling.
// The table has a single read port. A previous result that is not yet taken holds the
// sequencer in its hand-off state; a finished result waits in the output register
// while the next beat is accepted.
module block_table_allocator_core #(
    parameter int NUM_BLOCKS  = bta_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = bta_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_bytes[14:0], release_first[15], offset[30:16]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // start_offset[13:0], free_bytes[28:14]
    output logic [1:0]  m_axis_tuser    // status
);
    import bta_pkg::*;

    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam logic [CW-1:0]      NB_C       = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0]      LAST_BLK   = CW'(NUM_BLOCKS - 1);
    localparam logic [31:0]        HEAP_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [31:0]        BB32       = 32'(BLOCK_BYTES);
    localparam logic [FREE_W-1:0]  BB_F       = BB32[FREE_W-1:0];
    localparam logic [START_W-1:0] BB_S       = BB32[START_W-1:0];
    localparam logic [DIV_W-1:0]   ROUND_ADD  = DIV_W'(BLOCK_BYTES - 1);
    localparam logic [DIV_W-1:0]   NB_D       = DIV_W'(NUM_BLOCKS);

    t_state r_state, n_state;
    logic [CW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_len, n_len;
    logic [CW-1:0]      r_start_blk, n_start_blk;
    logic [DIV_W-1:0]   r_need, n_need;
    logic               r_cmd, n_cmd;
    logic               r_rel, n_rel;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [1:0]         r_status, n_status;
    logic [FREE_W-1:0]  r_free, n_free;
    logic               r_m_valid, n_m_valid;
    logic [1:0]         r_m_status, n_m_status;
    logic [START_W-1:0] r_m_start, n_m_start;
    logic [FREE_W-1:0]  r_m_free, n_m_free;

    logic [CW-1:0] r_map [NUM_BLOCKS];
    logic [CW-1:0] r_rd_data;
    logic          mem_we;
    logic [CW-1:0] mem_wdata;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic [REQ_W-1:0] in_req;
    logic             in_rel;
    logic [OFF_W-1:0] in_off;
    logic             in_off_ok;
    logic             r_off_ok;

    assign in_req    = s_axis_tdata[14:0];
    assign in_rel    = s_axis_tdata[15];
    assign in_off    = s_axis_tdata[30:16];
    assign in_off_ok = (32'(in_off) < HEAP_BYTES);
    assign r_off_ok  = (32'(r_off) < HEAP_BYTES);

    bta_div #(
        .DIVISOR(BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_addr[AW-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_map[n_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_free    <= HEAP_BYTES[FREE_W-1:0];
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_free    <= n_free;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_len       <= n_len;
        r_start_blk <= n_start_blk;
        r_need      <= n_need;
        r_cmd       <= n_cmd;
        r_rel       <= n_rel;
        r_off       <= n_off;
        r_status    <= n_status;
        r_m_status  <= n_m_status;
        r_m_start   <= n_m_start;
        r_m_free    <= n_m_free;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_len        = r_len;
        n_start_blk  = r_start_blk;
        n_need       = r_need;
        n_cmd        = r_cmd;
        n_rel        = r_rel;
        n_off        = r_off;
        n_status     = r_status;
        n_free       = r_free;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_status   = r_m_status;
        n_m_start    = r_m_start;
        n_m_free     = r_m_free;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(in_off);

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == LAST_BLK) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd       = s_axis_tuser;
                    n_rel       = in_rel;
                    n_off       = in_off;
                    n_start_blk = '0;
                    n_status    = ST_OK;
                    if (s_axis_tuser == CMD_FREE) begin
                        if (in_off_ok) begin
                            div_start    = 1'b1;
                            div_dividend = DIV_W'(in_off);
                            n_state      = S_DIV_OFF;
                        end else begin
                            n_status = ST_IGNORED;
                            n_state  = S_DONE;
                        end
                    end else if (in_req == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(in_req) + ROUND_ADD;
                        n_state      = S_DIV_REQ;
                    end
                end
            end
            S_DIV_REQ: begin
                if (div_done) begin
                    n_need = div_quo;
                    if (r_rel && r_off_ok) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(r_off);
                        n_state      = S_DIV_OFF;
                    end else begin
                        n_state = S_SCAN_GO;
                    end
                end
            end
            S_DIV_OFF: begin
                if (div_done) begin
                    n_addr  = div_quo[CW-1:0];
                    n_state = S_REL_LEN;
                end
            end
            S_REL_LEN: begin
                n_len   = r_rd_data;
                n_cnt   = '0;
                n_state = S_REL;
            end
            S_REL: begin
                if (r_cnt < r_len && r_addr < NB_C) begin
                    if (r_rd_data != '0) begin
                        mem_we = 1'b1;
                        n_free = r_free + BB_F;
                    end
                    n_cnt  = r_cnt + 1'b1;
                    n_addr = r_addr + 1'b1;
                end else if (r_cmd == CMD_FREE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_GO;
                end
            end
            S_SCAN_GO: begin
                n_addr = LAST_BLK;
                n_cnt  = '0;
                if (r_need <= NB_D) begin
                    n_state = S_SCAN;
                end else begin
                    n_status = ST_NOFIT;
                    n_state  = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_rd_data == '0 && (DIV_W'(r_cnt) + 1'b1) == r_need) begin
                    n_start_blk = r_addr;
                    n_cnt       = r_need[CW-1:0];
                    n_state     = S_MARK;
                end else begin
                    n_cnt = (r_rd_data == '0) ? r_cnt + 1'b1 : '0;
                    if (r_addr == '0) begin
                        n_status = ST_NOFIT;
                        n_state  = S_DONE;
                    end else begin
                        n_addr = r_addr - 1'b1;
                    end
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = r_need[CW-1:0];
                n_free    = r_free - BB_F;
                n_addr    = r_addr + 1'b1;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_start  = START_W'(r_start_blk) * BB_S;
                    n_m_free   = r_free;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {3'b000, r_m_free, r_m_start};

endmodule
